/* src/pts_pkg.sv */
// Package with types, constants and codes shared by the scheduler files.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned NumTasksDef   = 8;
  localparam logic [31:0] PrioTableRst  = 32'h0000_0356;

  typedef enum logic [1:0] {
    OP_QUEUE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PARK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_READY_FULL = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_DELAY_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] task_id;
    logic [7:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       dispatch_valid;
    logic [2:0] dispatched_task;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the input word
    logic push_in;    // append the input task to the ready store
    logic park_in;    // place input task in the lowest free delay slot
    logic scan_clr;   // start a ready-store scan
    logic scan_step;  // compare one ready entry
    logic remove;     // remove best entry, one shift step
    logic cd_clr;     // start countdown pass
    logic cd_step;    // process one delay slot
    logic finish;     // write the result word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] opcode;
    logic       delay_zero;
    logic       scan_last;
    logic       ready_empty;
    logic       shift_done;
    logic       cd_last;
  } sts_t;

endpackage
`default_nettype wire

/* src/pts_datapath.sv */
// Datapath: ready store, delay store, scan and countdown logic.
`timescale 1ns / 1ps
`default_nettype none
module pts_datapath import pts_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic [31:0] prio_i,
  input  wire in_word_t  in_i,
  input  wire cmd_t      cmd_i,
  output sts_t           sts_o,
  output out_word_t      out_o
);

  localparam int unsigned Iw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned Cw = $clog2(QueueDepth + 1);

  logic [2:0] ready_q [QueueDepth];
  logic [2:0] ptask_q [QueueDepth];
  logic [7:0] prem_q  [QueueDepth];
  logic [QueueDepth-1:0] pvalid_q;
  logic [Cw-1:0] rcount_q;
  in_word_t   word_q;
  logic [Iw-1:0] idx_q, best_q;
  logic [3:0] bestp_q;
  logic [1:0] status_q;
  logic       dv_q;
  logic [2:0] dt_q;
  out_word_t  out_q;

  function automatic logic [3:0] prio_of(logic [31:0] t, logic [2:0] id);
    prio_of = t[{id, 2'b00} +: 4];
  endfunction

  logic rfull;
  assign rfull = (rcount_q == Cw'(QueueDepth));

  // Lowest free delay slot.
  logic          free_any;
  logic [Iw-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int s = QueueDepth - 1; s >= 0; s--) begin
      if (!pvalid_q[s]) begin
        free_any = 1'b1;
        free_idx = Iw'(s);
      end
    end
  end

  logic [3:0] cur_p;
  assign cur_p = prio_of(prio_i, ready_q[idx_q]);
  logic [7:0] dec;
  assign dec = (prem_q[idx_q] != 8'd0) ? prem_q[idx_q] - 8'd1 : 8'd0;

  assign sts_o.opcode      = word_q.opcode;
  assign sts_o.delay_zero  = (word_q.delay_ticks == 8'd0);
  assign sts_o.scan_last   = ((Cw+1)'(idx_q) + (Cw+1)'(1) >= (Cw+1)'(rcount_q));
  assign sts_o.ready_empty = (rcount_q == '0);
  assign sts_o.shift_done  = ((Cw+1)'(best_q) + (Cw+1)'(1) >= (Cw+1)'(rcount_q));
  assign sts_o.cd_last     = (idx_q == Iw'(QueueDepth - 1));
  assign out_o = out_q;

  // Stores without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= in_i;
    end
    if (cmd_i.push_in && !rfull) begin
      ready_q[rcount_q[Iw-1:0]] <= word_q.task_id;
    end
    if (cmd_i.park_in && free_any) begin
      ptask_q[free_idx] <= word_q.task_id;
      prem_q[free_idx]  <= word_q.delay_ticks;
    end
    if (cmd_i.scan_clr) begin
      idx_q <= '0; best_q <= '0; bestp_q <= prio_of(prio_i, ready_q[0]);
    end
    if (cmd_i.scan_step) begin
      if (cur_p > bestp_q) begin
        best_q <= idx_q; bestp_q <= cur_p;
      end
      idx_q <= idx_q + Iw'(1);
      if (sts_o.scan_last) begin
        dt_q <= (cur_p > bestp_q) ? ready_q[idx_q] : ready_q[best_q];
      end
    end
    if (cmd_i.remove && !sts_o.shift_done) begin
      ready_q[best_q] <= ready_q[best_q + Iw'(1)];
      best_q <= best_q + Iw'(1);
    end
    if (cmd_i.cd_clr) begin
      idx_q <= '0;
    end
    if (cmd_i.cd_step) begin
      if (pvalid_q[idx_q]) begin
        prem_q[idx_q] <= dec;
        if (dec == 8'd0 && !rfull) ready_q[rcount_q[Iw-1:0]] <= ptask_q[idx_q];
      end
      idx_q <= idx_q + Iw'(1);
    end
    if (cmd_i.finish) begin
      out_q.status          <= status_q;
      out_q.dispatch_valid  <= dv_q;
      out_q.dispatched_task <= dv_q ? dt_q : 3'd0;
    end
  end

  // Control state of the stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0; rcount_q <= '0; status_q <= ST_OK; dv_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        status_q <= ST_OK; dv_q <= 1'b0;
      end
      if (cmd_i.push_in) begin
        if (rfull) status_q <= ST_READY_FULL;
        else rcount_q <= rcount_q + Cw'(1);
      end
      if (cmd_i.park_in) begin
        if (free_any) pvalid_q[free_idx] <= 1'b1;
        else status_q <= ST_DELAY_FULL;
      end
      if (cmd_i.scan_clr && rcount_q == '0) status_q <= ST_EMPTY;
      if (cmd_i.scan_step && sts_o.scan_last) dv_q <= 1'b1;
      if (cmd_i.remove && sts_o.shift_done) rcount_q <= rcount_q - Cw'(1);
      if (cmd_i.cd_step && pvalid_q[idx_q] && dec == 8'd0 && !rfull) begin
        pvalid_q[idx_q] <= 1'b0;
        rcount_q <= rcount_q + Cw'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* src/pts_ctrl.sv */
// Controller state machine that sequences each input word.
`timescale 1ns / 1ps
`default_nettype none
module pts_ctrl import pts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DEC    = 8'b0000_0010,
    S_SCAN0  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_REMOVE = 8'b0001_0000,
    S_CD     = 8'b0010_0000,
    S_FIN    = 8'b0100_0000,
    S_CD0    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  // The input side stays closed while a result waits in the output register.
  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ov_d    = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.opcode)
          OP_QUEUE: begin cmd_o.push_in = 1'b1; state_d = S_FIN; end
          OP_TICK:  begin cmd_o.scan_clr = 1'b1; state_d = S_SCAN0; end
          OP_PARK: begin
            if (sts_i.delay_zero) cmd_o.push_in = 1'b1;
            else cmd_o.park_in = 1'b1;
            state_d = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SCAN0: begin
        state_d = sts_i.ready_empty ? S_CD0 : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_REMOVE;
      end
      S_REMOVE: begin
        cmd_o.remove = 1'b1;
        if (sts_i.shift_done) state_d = S_CD0;
      end
      S_CD0: begin
        cmd_o.cd_clr = 1'b1;
        state_d = S_CD;
      end
      S_CD: begin
        cmd_o.cd_step = 1'b1;
        if (sts_i.cd_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (!ov_q) begin
          cmd_o.finish = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d;
    end
  end

endmodule
`default_nettype wire

/* src/priority_task_scheduler_with_delay_core.sv */
// Top level of the priority task scheduler with a delay store.
//  channel | direction | handshake            | word
//  in      | in        | in_valid_i/in_ready_o | in_word_t
//  out     | out       | out_valid_o/out_ready_i | out_word_t
//  cfg     | in        | cfg_valid_i/cfg_ready_o | 32-bit priority table
// Queue and park words go through decode and finish. A tick runs the
// ready scan, the removal shift and the countdown pass over the delay
// store, each one entry a cycle.
// Reset is asynchronous and needs no clearing pass.
// A waiting result holds the next word off until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module priority_task_scheduler_with_delay_core import pts_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic [31:0] prio_q;

  // Priority table register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prio_q <= PrioTableRst;
    else if (cfg_valid_i) prio_q <= cfg_data_i;
  end

  pts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pts_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i, .rst_ni, .prio_i(prio_q), .in_i(in_data_i), .cmd_i(cmd),
    .sts_o(sts), .out_o(out_data_o)
  );

endmodule
`default_nettype wire

/* src/pts_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pts_checker import pts_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_o
);

  // A waiting result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // No new word is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken with result pending");

  // A word accepted cannot yield a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result too early");

  // Dispatch goes with ok status and an empty tick never dispatches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dispatch_valid |-> out_data_o.status == ST_OK)
    else $error("dispatch with bad status");

endmodule

bind priority_task_scheduler_with_delay_core pts_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_data_o
);
`default_nettype wire

/* test/tb_priority_task_scheduler_with_delay_core.sv */
// Self-checking testbench for the priority task scheduler core.
`timescale 1ns / 1ps
module tb_priority_task_scheduler_with_delay_core;
  import pts_pkg::*;

  localparam int Depth = 16;
  localparam int CycleLimit = 900000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  priority_task_scheduler_with_delay_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Scheduler shadow state.
  logic [31:0] sh_prio;
  logic [2:0] sh_ready[Depth];
  int sh_rcount;
  logic [2:0] sh_ptask[Depth];
  logic [7:0] sh_prem[Depth];
  bit sh_pvalid[Depth];

  out_word_t pending_words[$];
  int mismatches = 0;
  int words_sent = 0;
  int words_seen = 0;
  int cycles = 0;
  bit idle_free = 1'b0;
  bit hold_out = 1'b0;

  function automatic logic [3:0] prio_of(logic [2:0] id);
    return sh_prio[4*id +: 4];
  endfunction

  function automatic bit ready_append(logic [2:0] id);
    if (sh_rcount >= Depth) return 1'b0;
    sh_ready[sh_rcount] = id;
    sh_rcount++;
    return 1'b1;
  endfunction

  // Predict the result word of one input word and update the shadow state.
  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    int best;
    r = '0;
    r.status = ST_OK;
    case (opcode_e'(w.opcode))
      OP_QUEUE: begin
        if (!ready_append(w.task_id)) r.status = ST_READY_FULL;
      end
      OP_TICK: begin
        if (sh_rcount == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < sh_rcount; i++)
            if (prio_of(sh_ready[i]) > prio_of(sh_ready[best])) best = i;
          r.dispatch_valid = 1'b1;
          r.dispatched_task = sh_ready[best];
          for (int i = best; i + 1 < sh_rcount; i++) sh_ready[i] = sh_ready[i+1];
          sh_rcount--;
        end
        // Countdown pass over the delay store.
        for (int s = 0; s < Depth; s++) begin
          if (sh_pvalid[s]) begin
            if (sh_prem[s] != 0) sh_prem[s]--;
            if (sh_prem[s] == 0 && ready_append(sh_ptask[s])) sh_pvalid[s] = 1'b0;
          end
        end
      end
      OP_PARK: begin
        if (w.delay_ticks == 0) begin
          if (!ready_append(w.task_id)) r.status = ST_READY_FULL;
        end else begin
          r.status = ST_DELAY_FULL;
          for (int s = 0; s < Depth; s++) begin
            if (!sh_pvalid[s]) begin
              sh_pvalid[s] = 1'b1;
              sh_ptask[s] = w.task_id;
              sh_prem[s] = w.delay_ticks;
              r.status = ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one word and queue its expected result.
  task automatic send_word(in_word_t w, bit has_fixed, out_word_t fixed);
    out_word_t exp_w;
    while (!idle_free && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    exp_w = schedule_word(w);
    if (has_fixed && exp_w !== fixed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with shadow: %h vs %h", fixed, exp_w);
    end
    in_data_i <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_words.push_back(exp_w);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Write the priority table once every result has arrived.
  task automatic write_table(logic [31:0] v);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sh_prio = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_word_t mk(opcode_e op, int id, int n);
    in_word_t w;
    w.opcode = op;
    w.task_id = 3'(id);
    w.delay_ticks = 8'(n);
    return w;
  endfunction

  function automatic out_word_t res(status_e st, bit dv, int dt);
    out_word_t r;
    r.status = st;
    r.dispatch_valid = dv;
    r.dispatched_task = 3'(dt);
    return r;
  endfunction

  // Receiver side: random stalls and comparison against the oldest expectation.
  always @(negedge clk_i) begin
    if (hold_out) out_ready_i <= 1'b0;
    else out_ready_i <= idle_free || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    out_word_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data_o);
      end else begin
        e = pending_words.pop_front();
        if (out_data_o.status !== e.status || out_data_o.dispatch_valid !== e.dispatch_valid
            || out_data_o.dispatched_task !== e.dispatched_task) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d dv=%0d dt=%0d, got st=%0d dv=%0d dt=%0d",
                     e.status, e.dispatch_valid, e.dispatched_task, out_data_o.status,
                     out_data_o.dispatch_valid, out_data_o.dispatched_task);
        end
      end
    end
  end

  // Directed table: fixed expectations where obvious, else shadow only.
  typedef struct {
    in_word_t w;
    bit fixed;
    out_word_t r;
  } row_t;

  initial begin
    row_t rows[$];
    logic [31:0] tables[5];
    int k;
    int op_pick;
    sh_prio = PrioTableRst;
    sh_rcount = 0;
    for (int s = 0; s < Depth; s++) sh_pvalid[s] = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows.push_back('{mk(OP_TICK, 7, 255), 1, res(ST_EMPTY, 0, 0)});
    rows.push_back('{mk(OP_NONE, 7, 255), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_QUEUE, 2, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_QUEUE, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_QUEUE, 0, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_QUEUE, 7, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_TICK, 0, 0), 1, res(ST_OK, 1, 0)});
    rows.push_back('{mk(OP_PARK, 1, 0), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_PARK, 5, 1), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_PARK, 6, 1), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_PARK, 3, 255), 1, res(ST_OK, 0, 0)});
    rows.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    rows.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    for (int i = 0; i < 15; i++) rows.push_back('{mk(OP_PARK, i % 8, 2), 0, '0});
    rows.push_back('{mk(OP_PARK, 4, 9), 1, res(ST_DELAY_FULL, 0, 0)});
    for (int i = 0; i < 12; i++) rows.push_back('{mk(OP_QUEUE, 7 - (i % 8), 0), 0, '0});
    rows.push_back('{mk(OP_QUEUE, 1, 0), 1, res(ST_READY_FULL, 0, 0)});
    rows.push_back('{mk(OP_PARK, 1, 0), 1, res(ST_READY_FULL, 0, 0)});
    // Expiry while the ready store is full keeps tasks parked.
    rows.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    rows.push_back('{mk(OP_TICK, 0, 0), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].r);
    // Drain everything so the random part starts from a known point.
    for (int i = 0; i < 36; i++) send_word(mk(OP_TICK, 0, 0), 0, '0);

    tables = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0123_4567, 32'hF0F0_0F0F, 32'h0000_0356};
    for (int phase = 0; phase < 5; phase++) begin
      write_table(phase == 4 ? $urandom() : tables[phase]);
      idle_free = (phase == 2);
      for (int i = 0; i < 190; i++) begin
        // Long receiver hold-off so the block backs up and stalls its input.
        if (phase == 1 && i == 20) begin
          fork
            begin
              hold_out = 1'b1;
              k = 0;
              while (k < 400) begin @(negedge clk_i); k++; end
              hold_out = 1'b0;
            end
          join_none
        end
        op_pick = $urandom_range(99);
        if (op_pick < 35) send_word(mk(OP_QUEUE, $urandom_range(7), $urandom_range(255)), 0, '0);
        else if (op_pick < 70) send_word(mk(OP_TICK, $urandom_range(7), $urandom_range(255)), 0, '0);
        else if (op_pick < 97)
          send_word(mk(OP_PARK, $urandom_range(7),
                       ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4)), 0, '0);
        else send_word(mk(OP_NONE, $urandom_range(7), $urandom_range(255)), 0, '0);
      end
    end
    idle_free = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Sent %0d words and checked %0d results over five priority tables,",
             words_sent, words_seen);
    $display("including full stores, empty ticks, expiries and a long output stall.");
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
